[design/mmsr_pkg.sv]
// mmsr_pkg: shared widths, codes, state encoding and slot entry layout
// for the mapping slot registry; no dependencies
package mmsr_pkg;

   localparam int ACT_W      = 3;
   localparam int TASK_W     = 16;
   localparam int GEN_W      = 32;
   localparam int CAP_W      = 8;
   localparam int PHYS_W     = 52;
   localparam int BYTES_W    = 40;
   localparam int ROOT_W     = 52;
   localparam int VA_W       = 48;
   localparam int RS_W       = 33;
   localparam int STAT_W     = 3;
   localparam int IDX_OUT_W  = 4;
   localparam int LIVE_W     = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [RS_W-1:0] REGION_RESET = 33'd65536;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_VA_BASE     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE = 4'd1;

   typedef enum logic [ACT_W-1:0] {
      ACT_MAP   = 3'd0,
      ACT_UNMAP = 3'd1,
      ACT_INVAL = 3'd2,
      ACT_DRAIN = 3'd3,
      ACT_CLEAR = 3'd4,
      ACT_QUERY = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_REJECTED = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_CLEARED  = 3'd4,
      STAT_NONE     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_MAP_MUL,
      S_MAP_WR,
      S_WALK,
      S_SHOW,
      S_SINGLE
   } state_type;

   typedef struct packed {
      logic [VA_W-1:0]   va;
      logic [ROOT_W-1:0] root;
      logic [CAP_W-1:0]  cap;
      logic [GEN_W-1:0]  gen;
      logic [TASK_W-1:0] task_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[design/mmsr_req_if.sv]
// mmsr_req_if: request channel of the mapping slot registry
// depends on mmsr_pkg for field widths
interface mmsr_req_if;
   logic                             valid;
   logic                             ready;
   logic [mmsr_pkg::ACT_W-1:0]       action;
   logic [mmsr_pkg::TASK_W-1:0]      task_id;
   logic [mmsr_pkg::GEN_W-1:0]       task_gen;
   logic [mmsr_pkg::CAP_W-1:0]       cap_handle;
   logic                             cap_revoked;
   logic                             cap_is_io;
   logic [mmsr_pkg::PHYS_W-1:0]      phys_base;
   logic [mmsr_pkg::BYTES_W-1:0]     range_bytes;
   logic [mmsr_pkg::ROOT_W-1:0]      page_root;
   logic [mmsr_pkg::VA_W-1:0]        vaddr;

   modport source (
      output valid, action, task_id, task_gen, cap_handle, cap_revoked, cap_is_io,
             phys_base, range_bytes, page_root, vaddr,
      input  ready
   );
   modport sink (
      input  valid, action, task_id, task_gen, cap_handle, cap_revoked, cap_is_io,
             phys_base, range_bytes, page_root, vaddr,
      output ready
   );
endinterface

[design/mmsr_rsp_if.sv]
// mmsr_rsp_if: result channel of the mapping slot registry
// depends on mmsr_pkg for field widths
interface mmsr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mmsr_pkg::STAT_W-1:0]      status;
   logic [mmsr_pkg::VA_W-1:0]        map_vaddr;
   logic [mmsr_pkg::CAP_W-1:0]       slot_cap;
   logic [mmsr_pkg::ROOT_W-1:0]      slot_root;
   logic [mmsr_pkg::IDX_OUT_W-1:0]   slot_index;
   logic [mmsr_pkg::LIVE_W-1:0]      live_slots;
   logic                             owner_match;
   logic                             last;

   modport source (
      output valid, status, map_vaddr, slot_cap, slot_root, slot_index, live_slots,
             owner_match, last,
      input  ready
   );
   modport sink (
      input  valid, status, map_vaddr, slot_cap, slot_root, slot_index, live_slots,
             owner_match, last,
      output ready
   );
endinterface

[design/mmsr_csr_if.sv]
// mmsr_csr_if: register write channel of the mapping slot registry
// depends on mmsr_pkg for field widths
interface mmsr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mmsr_pkg::CSR_IDX_W-1:0]    index;
   logic [mmsr_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[design/mmsr_ram.sv]
// mmsr_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module mmsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mmio_mapping_slot_registry.sv]
// mmio_mapping_slot_registry: top level of the mapping slot registry
// depends on mmsr_pkg, mmsr_req_if, mmsr_rsp_if, mmsr_csr_if and mmsr_ram
//
//   channel   | dir | handshake       | carries
//   ----------+-----+-----------------+------------------------------------------
//   req_chan  | in  | valid / ready   | action, task, capability, range, root, va
//   rsp_chan  | out | valid / ready   | status, slot fields, live count, last
//   csr_chan  | in  | valid / ready   | register index and write data
//
// one request at a time: a scan reads one slot entry per cycle through the
// slot ram's single read port. after the scan, a map multiplies its slot index by
// the region size and writes the slot; full, not found and none matched give a
// single result, and a walk skips unmatched slots below the last match and reads
// and shows each freed or found slot. rejected and unknown requests skip the scan.
// reset clears the occupancy bits at once; the slot ram needs no clearing.
// a stalled result holds in the output register and stalls the sequencer.
module mmio_mapping_slot_registry #(
   parameter int SLOTS      = 16,
   parameter int PAGE_BYTES = 4096
) (
   input logic        clock,
   input logic        reset,
   mmsr_req_if.sink   req_chan,
   mmsr_rsp_if.source rsp_chan,
   mmsr_csr_if.sink   csr_chan
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = mmsr_pkg::RS_W + IW;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   // page size is a power of two, so rounding up is a mask
   localparam logic [mmsr_pkg::RS_W-1:0] PAGE_MASK = mmsr_pkg::RS_W'(PAGE_BYTES - 1);

   mmsr_pkg::state_type state_ff, state_in;

   logic [mmsr_pkg::VA_W-1:0]   va_base_ff, va_base_in;
   logic [mmsr_pkg::RS_W-1:0]   region_ff, region_in;

   logic [SLOTS-1:0]            used_ff, used_in;
   logic [SLOTS-1:0]            hit_ff, hit_in;
   logic [CW-1:0]               hit_cnt_ff, hit_cnt_in;
   logic [IW-1:0]               first_ff, first_in;
   logic                        any_ff, any_in;
   logic [IW-1:0]               scan_ff, scan_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]               walk_ff, walk_in;
   logic [CW-1:0]               rem_ff, rem_in;
   logic [CW-1:0]               live_ff, live_in;
   logic [PW-1:0]               prod_ff, prod_in;

   logic [mmsr_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [mmsr_pkg::TASK_W-1:0] task_ff, task_in;
   logic [mmsr_pkg::GEN_W-1:0]  gen_ff, gen_in;
   logic [mmsr_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [mmsr_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [mmsr_pkg::VA_W-1:0]   va_ff, va_in;
   mmsr_pkg::status_type        single_st_ff, single_st_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   mmsr_pkg::status_type          rsp_st_ff, rsp_st_in;
   logic [mmsr_pkg::VA_W-1:0]     rsp_va_ff, rsp_va_in;
   logic [mmsr_pkg::CAP_W-1:0]    rsp_cap_ff, rsp_cap_in;
   logic [mmsr_pkg::ROOT_W-1:0]   rsp_root_ff, rsp_root_in;
   logic [mmsr_pkg::IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [mmsr_pkg::LIVE_W-1:0]   rsp_live_ff, rsp_live_in;
   logic                          rsp_match_ff, rsp_match_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                         ram_wr_en, ram_rd_en;
   logic [IW-1:0]                ram_wr_addr, ram_rd_addr;
   mmsr_pkg::entry_type          ram_wr_data, ram_rd_data;

   logic                         accept, csr_wr, out_free;
   logic                         act_known, map_reject, hit;
   logic [mmsr_pkg::RS_W-1:0]    region_floor;
   logic [mmsr_pkg::VA_W-1:0]    va_new;

   mmsr_ram #(
      .WIDTH (mmsr_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == mmsr_pkg::S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign csr_wr   = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_vld_ff || rsp_chan.ready;

   // rounded size exceeds region exactly when bytes exceed the region
   // rounded down to whole pages
   assign region_floor = region_ff & ~PAGE_MASK;
   assign act_known    = (req_chan.action <= mmsr_pkg::ACT_QUERY);
   assign map_reject   = req_chan.cap_revoked || req_chan.cap_is_io ||
                         (req_chan.phys_base == '0) || (req_chan.range_bytes == '0) ||
                         (req_chan.page_root == '0) ||
                         (req_chan.range_bytes > mmsr_pkg::BYTES_W'(region_floor));

   assign va_new = va_base_ff + mmsr_pkg::VA_W'(prod_ff);

   // shared compare unit, fed by the ram entry read in the previous cycle
   always_comb begin
      hit = 1'b0;
      case (act_ff)
         mmsr_pkg::ACT_MAP:   hit = !used_ff[cmp_idx_ff] && !any_ff;
         mmsr_pkg::ACT_UNMAP,
         mmsr_pkg::ACT_QUERY: hit = used_ff[cmp_idx_ff] && !any_ff &&
                                    (ram_rd_data.va == va_ff) &&
                                    (ram_rd_data.task_id == task_ff) &&
                                    (ram_rd_data.gen == gen_ff);
         mmsr_pkg::ACT_INVAL: hit = used_ff[cmp_idx_ff] && (ram_rd_data.cap == cap_ff);
         mmsr_pkg::ACT_DRAIN: hit = used_ff[cmp_idx_ff] &&
                                    (ram_rd_data.task_id == task_ff);
         mmsr_pkg::ACT_CLEAR: hit = used_ff[cmp_idx_ff];
         default:             hit = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmsr_pkg::S_IDLE: begin
            if (accept) begin
               if (!act_known || ((req_chan.action == mmsr_pkg::ACT_MAP) && map_reject)) begin
                  state_in = mmsr_pkg::S_SINGLE;
               end else begin
                  state_in = mmsr_pkg::S_SCAN;
               end
            end
         end
         mmsr_pkg::S_SCAN: begin
            if (scan_ff == LAST_IDX) begin
               state_in = mmsr_pkg::S_DRAIN;
            end
         end
         mmsr_pkg::S_DRAIN:  state_in = mmsr_pkg::S_DECIDE;
         mmsr_pkg::S_DECIDE: begin
            if (!any_ff) begin
               state_in = mmsr_pkg::S_SINGLE;
            end else if (act_ff == mmsr_pkg::ACT_MAP) begin
               state_in = mmsr_pkg::S_MAP_MUL;
            end else begin
               state_in = mmsr_pkg::S_WALK;
            end
         end
         mmsr_pkg::S_MAP_MUL: state_in = mmsr_pkg::S_MAP_WR;
         mmsr_pkg::S_MAP_WR: begin
            if (out_free) begin
               state_in = mmsr_pkg::S_IDLE;
            end
         end
         mmsr_pkg::S_WALK: begin
            if (hit_ff[walk_ff]) begin
               state_in = mmsr_pkg::S_SHOW;
            end
         end
         mmsr_pkg::S_SHOW: begin
            if (out_free) begin
               state_in = (rem_ff == CW'(1)) ? mmsr_pkg::S_IDLE : mmsr_pkg::S_WALK;
            end
         end
         mmsr_pkg::S_SINGLE: begin
            if (out_free) begin
               state_in = mmsr_pkg::S_IDLE;
            end
         end
         default: state_in = mmsr_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      va_base_in   = va_base_ff;
      region_in    = region_ff;
      used_in      = used_ff;
      hit_in       = hit_ff;
      hit_cnt_in   = hit_cnt_ff;
      first_in     = first_ff;
      any_in       = any_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      walk_in      = walk_ff;
      rem_in       = rem_ff;
      live_in      = live_ff;
      prod_in      = prod_ff;
      act_in       = act_ff;
      task_in      = task_ff;
      gen_in       = gen_ff;
      cap_in       = cap_ff;
      root_in      = root_ff;
      va_in        = va_ff;
      single_st_in = single_st_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_va_in    = rsp_va_ff;
      rsp_cap_in   = rsp_cap_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_live_in  = rsp_live_ff;
      rsp_match_in = rsp_match_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = first_ff;
      ram_wr_data  = '{va: va_new, root: root_ff, cap: cap_ff, gen: gen_ff,
                       task_id: task_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff;

      if (csr_wr) begin
         case (csr_chan.index)
            mmsr_pkg::CSR_VA_BASE:     va_base_in = csr_chan.wdata[mmsr_pkg::VA_W-1:0];
            mmsr_pkg::CSR_REGION_SIZE: region_in  = csr_chan.wdata[mmsr_pkg::RS_W-1:0];
            default: ;
         endcase
      end

      if (cmp_vld_ff && hit) begin
         hit_in[cmp_idx_ff] = 1'b1;
         hit_cnt_in         = hit_cnt_ff + CW'(1);
         any_in             = 1'b1;
         if (!any_ff) begin
            first_in = cmp_idx_ff;
         end
      end

      case (state_ff)
         mmsr_pkg::S_IDLE: begin
            if (accept) begin
               act_in       = req_chan.action;
               task_in      = req_chan.task_id;
               gen_in       = req_chan.task_gen;
               cap_in       = req_chan.cap_handle;
               root_in      = req_chan.page_root;
               va_in        = req_chan.vaddr;
               single_st_in = mmsr_pkg::STAT_REJECTED;
               scan_in      = '0;
               hit_in       = '0;
               hit_cnt_in   = '0;
               first_in     = '0;
               any_in       = 1'b0;
            end
         end
         mmsr_pkg::S_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ff;
            cmp_vld_in  = 1'b1;
            cmp_idx_in  = scan_ff;
            scan_in     = scan_ff + IW'(1);
         end
         mmsr_pkg::S_DECIDE: begin
            walk_in = '0;
            rem_in  = hit_cnt_ff;
            case (act_ff)
               mmsr_pkg::ACT_MAP: begin
                  single_st_in = mmsr_pkg::STAT_FULL;
                  if (any_ff) begin
                     live_in = live_ff + CW'(1);
                  end
               end
               mmsr_pkg::ACT_UNMAP: begin
                  single_st_in = mmsr_pkg::STAT_NOTFOUND;
                  if (any_ff) begin
                     live_in = live_ff - CW'(1);
                  end
               end
               mmsr_pkg::ACT_QUERY: single_st_in = mmsr_pkg::STAT_NOTFOUND;
               default: begin
                  single_st_in = mmsr_pkg::STAT_NONE;
                  live_in      = live_ff - hit_cnt_ff;
               end
            endcase
         end
         mmsr_pkg::S_MAP_MUL: begin
            prod_in = PW'(first_ff) * PW'(region_ff);
         end
         mmsr_pkg::S_MAP_WR: begin
            if (out_free) begin
               ram_wr_en         = 1'b1;
               used_in[first_ff] = 1'b1;
               rsp_vld_in        = 1'b1;
               rsp_st_in         = mmsr_pkg::STAT_OK;
               rsp_va_in         = va_new;
               rsp_cap_in        = cap_ff;
               rsp_root_in       = root_ff;
               rsp_idx_in        = mmsr_pkg::IDX_OUT_W'(first_ff);
               rsp_live_in       = mmsr_pkg::LIVE_W'(live_ff);
               rsp_match_in      = 1'b0;
               rsp_last_in       = 1'b1;
            end
         end
         mmsr_pkg::S_WALK: begin
            if (hit_ff[walk_ff]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = walk_ff;
            end else begin
               walk_in = walk_ff + IW'(1);
            end
         end
         mmsr_pkg::S_SHOW: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_va_in    = ram_rd_data.va;
               rsp_cap_in   = ram_rd_data.cap;
               rsp_root_in  = ram_rd_data.root;
               rsp_idx_in   = mmsr_pkg::IDX_OUT_W'(walk_ff);
               rsp_live_in  = mmsr_pkg::LIVE_W'(live_ff);
               rsp_last_in  = (rem_ff == CW'(1));
               rem_in       = rem_ff - CW'(1);
               walk_in      = walk_ff + IW'(1);
               if (act_ff == mmsr_pkg::ACT_QUERY) begin
                  rsp_st_in    = mmsr_pkg::STAT_OK;
                  rsp_match_in = 1'b1;
               end else begin
                  rsp_st_in        = mmsr_pkg::STAT_CLEARED;
                  rsp_match_in     = 1'b0;
                  used_in[walk_ff] = 1'b0;
               end
            end
         end
         mmsr_pkg::S_SINGLE: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_st_in    = single_st_ff;
               rsp_va_in    = '0;
               rsp_cap_in   = '0;
               rsp_root_in  = '0;
               rsp_idx_in   = '0;
               rsp_live_in  = mmsr_pkg::LIVE_W'(live_ff);
               rsp_match_in = 1'b0;
               rsp_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mmsr_pkg::S_IDLE;
         va_base_ff <= '0;
         region_ff  <= mmsr_pkg::REGION_RESET;
         used_ff    <= '0;
         live_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         va_base_ff <= va_base_in;
         region_ff  <= region_in;
         used_ff    <= used_in;
         live_ff    <= live_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      hit_ff       <= hit_in;
      hit_cnt_ff   <= hit_cnt_in;
      first_ff     <= first_in;
      any_ff       <= any_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      walk_ff      <= walk_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      act_ff       <= act_in;
      task_ff      <= task_in;
      gen_ff       <= gen_in;
      cap_ff       <= cap_in;
      root_ff      <= root_in;
      va_ff        <= va_in;
      single_st_ff <= single_st_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_va_ff    <= rsp_va_in;
      rsp_cap_ff   <= rsp_cap_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_live_ff  <= rsp_live_in;
      rsp_match_ff <= rsp_match_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.status      = rsp_st_ff;
   assign rsp_chan.map_vaddr   = rsp_va_ff;
   assign rsp_chan.slot_cap    = rsp_cap_ff;
   assign rsp_chan.slot_root   = rsp_root_ff;
   assign rsp_chan.slot_index  = rsp_idx_ff;
   assign rsp_chan.live_slots  = rsp_live_ff;
   assign rsp_chan.owner_match = rsp_match_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

[design/mmsr_checker.sv]
// mmsr_checker: port level assertions for the mapping slot registry,
// bound to the top level; depends on mmsr_pkg
module mmsr_checker #(
   parameter int SLOTS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mmsr_pkg::STAT_W-1:0]      rsp_status,
   input logic [mmsr_pkg::VA_W-1:0]        rsp_map_vaddr,
   input logic [mmsr_pkg::LIVE_W-1:0]      rsp_live_slots,
   input logic                             rsp_last
);

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_map_vaddr) && $stable(rsp_last)))
      else $error("stalled result changed");

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // no new request until the final result of a burst is out
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("request taken in the middle of a burst");

   // full is only reported when every slot is live
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == mmsr_pkg::STAT_FULL)) |->
         (rsp_live_slots == mmsr_pkg::LIVE_W'(SLOTS)))
      else $error("full reported with a free slot");

endmodule

bind mmio_mapping_slot_registry mmsr_checker #(.SLOTS(SLOTS)) u_mmsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_map_vaddr  (rsp_chan.map_vaddr),
   .rsp_live_slots (rsp_chan.live_slots),
   .rsp_last       (rsp_chan.last)
);
